@@ rtl/core/fdmd_pkg.sv @@
package fdmd_pkg;

    // frame geometry
    localparam int FRAME_PIXELS = 1048576;
    localparam int IDX_W        = $clog2(FRAME_PIXELS + 1);
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);

    // pixel and count widths
    localparam int COLOR_W = 8;
    localparam int GRAY_W  = 8;
    localparam int COUNT_W = 21;

    // gray conversion: (1868*b + 9617*g + 4899*r + 8192) >> 14
    localparam int PROD_W     = 22;
    localparam int GRAY_SHIFT = 14;
    localparam logic [PROD_W-1:0] COEF_BLUE  = PROD_W'(1868);
    localparam logic [PROD_W-1:0] COEF_GREEN = PROD_W'(9617);
    localparam logic [PROD_W-1:0] COEF_RED   = PROD_W'(4899);
    localparam logic [PROD_W-1:0] GRAY_ROUND = PROD_W'(8192);

    // queue between front and back, depth must be a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_ENABLE = 2'd2;

    localparam logic [GRAY_W-1:0]  DIFF_THRESHOLD_RST   = GRAY_W'(127);
    localparam logic [COUNT_W-1:0] MOTION_THRESHOLD_RST = COUNT_W'(1500);
    localparam logic               DETECTION_ENABLE_RST = 1'b1;

    // what the back part does with a pixel
    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_COMPARE
    } op_t;

    // one pixel word travelling from front to back
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [GRAY_W-1:0] gray;
        logic              report;
    } item_t;

    // configuration seen by the back part
    typedef struct packed {
        logic [GRAY_W-1:0]  diff_threshold;
        logic [COUNT_W-1:0] motion_pixel_threshold;
        logic               detection_enable;
    } cfg_t;

endpackage

@@ rtl/core/frame_difference_motion_detector.sv @@
// Frame-difference motion detector. Takes one RGB pixel per word, with
// end_of_frame on the last pixel of each frame, and converts it to 8-bit gray.
// The first frame after reset is stored as the reference (up to FRAME_PIXELS
// pixels, 1M x 8 single-port memory) and produces no result. In each later
// frame, pixels whose gray differs from the reference by more than
// diff_threshold are counted; at end of frame one word reports the count and
// whether it reached motion_pixel_threshold, if detection_enable is set.
// Throughput is one pixel per clock while in_stall is low, set by the gray
// multiply/add pipeline and one memory access per pixel; a frame's result
// word passes through stage 1, the queue and stage r into the output register.
// in_stall rises only when the four-entry queue between the front and back,
// counting the word in the multiply stage, is full, which happens when
// out_stall holds a frame result. The reference memory has no clearing pass.
// Write configuration only while the block is idle.
module frame_difference_motion_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fdmd_pkg::COLOR_W-1:0]     red,
    input  logic [fdmd_pkg::COLOR_W-1:0]     green,
    input  logic [fdmd_pkg::COLOR_W-1:0]     blue,
    input  logic                             end_of_frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             motion_detected,
    output logic [fdmd_pkg::COUNT_W-1:0]     changed_pixel_count,
    input  logic                             cfg_we,
    input  logic [fdmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                           push;
    fdmd_pkg::item_t                push_item;
    logic                           pop;
    logic                           head_valid;
    fdmd_pkg::item_t                head_item;
    logic [fdmd_pkg::Q_CNT_W-1:0]   q_level;
    fdmd_pkg::cfg_t                 cfg_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold         <= fdmd_pkg::DIFF_THRESHOLD_RST;
            cfg_reg.motion_pixel_threshold <= fdmd_pkg::MOTION_THRESHOLD_RST;
            cfg_reg.detection_enable       <= fdmd_pkg::DETECTION_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fdmd_pkg::CFG_DIFF_THRESHOLD:
                begin
                    cfg_reg.diff_threshold <= cfg_data[fdmd_pkg::GRAY_W-1:0];
                end
                fdmd_pkg::CFG_MOTION_THRESHOLD:
                begin
                    cfg_reg.motion_pixel_threshold <= cfg_data[fdmd_pkg::COUNT_W-1:0];
                end
                fdmd_pkg::CFG_DETECTION_ENABLE:
                begin
                    cfg_reg.detection_enable <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // front: gray conversion and classification
    fdmd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .q_level      (q_level),
        .push         (push),
        .push_item    (push_item)
    );

    // queue between front and back
    fdmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .level      (q_level)
    );

    // back: reference memory, compare, count and result
    fdmd_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .head_valid          (head_valid),
        .head_item           (head_item),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .motion_detected     (motion_detected),
        .changed_pixel_count (changed_pixel_count)
    );

endmodule

@@ rtl/core/fdmd_front.sv @@
module fdmd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fdmd_pkg::COLOR_W-1:0]  red,
    input  logic [fdmd_pkg::COLOR_W-1:0]  green,
    input  logic [fdmd_pkg::COLOR_W-1:0]  blue,
    input  logic                          end_of_frame,
    input  logic [fdmd_pkg::Q_CNT_W-1:0]  q_level,
    output logic                          push,
    output fdmd_pkg::item_t               push_item
);

    logic                           accept;
    logic                           s1_valid_reg;
    logic [fdmd_pkg::PROD_W-1:0]    prod_b_reg;
    logic [fdmd_pkg::PROD_W-1:0]    prod_g_reg;
    logic [fdmd_pkg::PROD_W-1:0]    prod_r_reg;
    fdmd_pkg::op_t                  s1_op_reg;
    logic [fdmd_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic                           s1_report_reg;
    fdmd_pkg::op_t                  op_next;
    logic                           report_next;

    logic                           ref_valid_reg;
    logic [fdmd_pkg::IDX_W-1:0]     ref_len_reg;
    logic [fdmd_pkg::IDX_W-1:0]     idx_reg;
    logic [fdmd_pkg::IDX_W-1:0]     idx_inc;
    logic                           idx_in_frame;
    logic [fdmd_pkg::Q_CNT_W:0]     q_demand;
    logic [fdmd_pkg::PROD_W-1:0]    gray_sum;

    // room check: the word in stage 1 and this one must both fit in the queue
    assign q_demand = {1'b0, q_level} + (fdmd_pkg::Q_CNT_W + 1)'(s1_valid_reg);
    assign in_stall = q_demand >= (fdmd_pkg::Q_CNT_W + 1)'(fdmd_pkg::Q_DEPTH);
    assign accept   = in_valid && !in_stall;

    // position tracking, saturating at the frame size
    assign idx_in_frame = idx_reg < fdmd_pkg::IDX_W'(fdmd_pkg::FRAME_PIXELS);
    assign idx_inc      = idx_in_frame ? idx_reg + fdmd_pkg::IDX_W'(1) : idx_reg;

    // classify the pixel
    always_comb
    begin
        op_next     = fdmd_pkg::OP_NONE;
        report_next = 1'b0;
        if (!ref_valid_reg)
        begin
            if (idx_in_frame)
            begin
                op_next = fdmd_pkg::OP_STORE;
            end
        end
        else
        begin
            if (idx_in_frame && (idx_reg < ref_len_reg))
            begin
                op_next = fdmd_pkg::OP_COMPARE;
            end
            report_next = end_of_frame;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
            ref_len_reg   <= '0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (end_of_frame)
                begin
                    idx_reg <= '0;
                    if (!ref_valid_reg)
                    begin
                        ref_valid_reg <= 1'b1;
                        ref_len_reg   <= idx_inc;
                    end
                end
                else
                begin
                    idx_reg <= idx_inc;
                end
            end
        end
    end

    // stage 1: color products and classification
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_b_reg    <= fdmd_pkg::PROD_W'(blue)  * fdmd_pkg::COEF_BLUE;
            prod_g_reg    <= fdmd_pkg::PROD_W'(green) * fdmd_pkg::COEF_GREEN;
            prod_r_reg    <= fdmd_pkg::PROD_W'(red)   * fdmd_pkg::COEF_RED;
            s1_op_reg     <= op_next;
            s1_addr_reg   <= idx_reg[fdmd_pkg::ADDR_W-1:0];
            s1_report_reg <= report_next;
        end
    end

    // stage 2: sum, round and push into the queue
    assign gray_sum = prod_b_reg + prod_g_reg + prod_r_reg + fdmd_pkg::GRAY_ROUND;

    assign push             = s1_valid_reg;
    assign push_item.op     = s1_op_reg;
    assign push_item.addr   = s1_addr_reg;
    assign push_item.gray   =
        gray_sum[fdmd_pkg::GRAY_SHIFT + fdmd_pkg::GRAY_W - 1:fdmd_pkg::GRAY_SHIFT];
    assign push_item.report = s1_report_reg;

endmodule

@@ rtl/core/fdmd_queue.sv @@
module fdmd_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  fdmd_pkg::item_t               push_item,
    input  logic                          pop,
    output logic                          head_valid,
    output fdmd_pkg::item_t               head_item,
    output logic [fdmd_pkg::Q_CNT_W-1:0]  level
);

    fdmd_pkg::item_t                slot_reg [fdmd_pkg::Q_DEPTH];
    logic [fdmd_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [fdmd_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [fdmd_pkg::Q_CNT_W-1:0]   level_reg;
    logic                           do_pop;

    assign head_valid = level_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + fdmd_pkg::Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + fdmd_pkg::Q_PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                level_reg <= level_reg + fdmd_pkg::Q_CNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                level_reg <= level_reg - fdmd_pkg::Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/fdmd_back.sv @@
module fdmd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdmd_pkg::cfg_t                cfg,
    input  logic                          head_valid,
    input  fdmd_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          motion_detected,
    output logic [fdmd_pkg::COUNT_W-1:0]  changed_pixel_count
);

    logic [fdmd_pkg::GRAY_W-1:0]    ref_mem [fdmd_pkg::FRAME_PIXELS];

    logic                           r_valid_reg;
    fdmd_pkg::op_t                  r_op_reg;
    logic [fdmd_pkg::GRAY_W-1:0]    r_gray_reg;
    logic                           r_report_reg;
    logic [fdmd_pkg::GRAY_W-1:0]    rdata_reg;
    logic [fdmd_pkg::COUNT_W-1:0]   count_reg;
    logic [fdmd_pkg::COUNT_W-1:0]   count_next;
    logic                           out_valid_reg;
    logic                           out_motion_reg;
    logic [fdmd_pkg::COUNT_W-1:0]   out_count_reg;

    logic [fdmd_pkg::GRAY_W-1:0]    diff;
    logic                           changed;
    logic                           emit;
    logic                           out_free;
    logic                           r_done;
    logic                           advance;

    // handshake between stage r, the output register and the queue
    assign emit     = r_valid_reg && r_report_reg && cfg.detection_enable;
    assign out_free = !out_valid_reg || !out_stall;
    assign r_done   = !emit || out_free;
    assign advance  = !r_valid_reg || r_done;
    assign pop      = head_valid && advance;

    // reference memory: store or read at pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head_item.op == fdmd_pkg::OP_STORE)
            begin
                ref_mem[head_item.addr] <= head_item.gray;
            end
            rdata_reg  <= ref_mem[head_item.addr];
            r_op_reg   <= head_item.op;
            r_gray_reg <= head_item.gray;
            r_report_reg <= head_item.report;
        end
    end

    // absolute difference and changed-pixel decision
    assign diff    = (r_gray_reg > rdata_reg) ? r_gray_reg - rdata_reg
                                              : rdata_reg - r_gray_reg;
    assign changed = (r_op_reg == fdmd_pkg::OP_COMPARE) && (diff > cfg.diff_threshold);

    // saturating count including this pixel
    assign count_next = (changed && (count_reg != '1)) ? count_reg + fdmd_pkg::COUNT_W'(1)
                                                       : count_reg;

    // stage r valid, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                r_valid_reg <= head_valid;
            end
            if (r_valid_reg && r_done)
            begin
                count_reg <= r_report_reg ? '0 : count_next;
            end
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            out_motion_reg <= count_next >= cfg.motion_pixel_threshold;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign motion_detected     = out_motion_reg;
    assign changed_pixel_count = out_count_reg;

endmodule
